[hdl/olgre_pkg.sv]
package olgre_pkg;

    localparam int MAX_BYTES = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    localparam logic [3:0] MAX_LEN = 4'(MAX_BYTES);

    localparam logic [7:0] BYTE_SYNC  = 8'h05;
    localparam logic [7:0] BYTE_RESET = 8'h04;
    localparam logic [7:0] BYTE_START = 8'h01;

    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_RX       = 3'd1;
    localparam logic [2:0] CMD_REQ      = 3'd2;
    localparam logic [2:0] CMD_TAKE_RES = 3'd3;
    localparam logic [2:0] CMD_TAKE_ERR = 3'd4;

    localparam logic [1:0] CFG_RESET_PERIOD    = 2'd0;
    localparam logic [1:0] CFG_REQUEST_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_ANSWER_TIMEOUT  = 2'd2;
    localparam logic [1:0] CFG_QUICK_WINDOW    = 2'd3;

    localparam logic [1:0] OUTCOME_NONE   = 2'd0;
    localparam logic [1:0] OUTCOME_RESULT = 2'd1;
    localparam logic [1:0] OUTCOME_ERROR  = 2'd2;

    typedef enum logic [4:0] {
        PH_INIT = 5'b00001,
        PH_IDLE = 5'b00010,
        PH_SYNC = 5'b00100,
        PH_SEND = 5'b01000,
        PH_RECV = 5'b10000
    } t_phase;

    typedef enum logic [3:0] {
        ACT_WAIT    = 4'b0001,
        ACT_PROCESS = 4'b0010,
        ACT_RETURN  = 4'b0100,
        ACT_ERROR   = 4'b1000
    } t_action;

    typedef enum logic [1:0] {
        EMIT_NONE  = 2'd0,
        EMIT_RESET = 2'd1,
        EMIT_FRAME = 2'd2
    } t_emit;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  rx_byte;
        logic [7:0]  func_code;
        logic [7:0]  dp_address;
        logic [3:0]  dp_length;
        logic        is_write;
        logic [63:0] write_data;
    } t_in;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        last;
        logic        accepted;
        logic        busy_res;
        logic [1:0]  outcome;
        logic        error_code;
        logic [63:0] result_data;
    } t_out;

    typedef struct packed {
        logic [15:0] reset_period_ms;
        logic [15:0] request_timeout_ms;
        logic [15:0] answer_timeout_ms;
        logic [7:0]  quick_window_ms;
    } t_cfg;

    typedef struct packed {
        t_emit       emit;
        logic        sync_prefix;
        logic [7:0]  func;
        logic [7:0]  addr;
        logic [3:0]  len;
        logic        is_write;
        logic [63:0] data;
        logic        accepted;
        logic        busy_res;
        logic [1:0]  outcome;
        logic        error_code;
        logic [63:0] result_data;
    } t_job;

endpackage

[hdl/olgre_front.sv]
module olgre_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  olgre_pkg::t_in   i_in,
    input  olgre_pkg::t_cfg  i_cfg,
    output logic             o_job_valid,
    output olgre_pkg::t_job  o_job,
    input  logic             i_job_ready
);

    olgre_pkg::t_phase  r_phase, n_phase;
    olgre_pkg::t_action r_action, n_action;
    logic [7:0]  r_func, n_func;
    logic [7:0]  r_addr, n_addr;
    logic [3:0]  r_len, n_len;
    logic        r_is_write, n_is_write;
    logic [63:0] r_data, n_data;
    logic [7:0]  r_rx_store [olgre_pkg::MAX_BYTES];
    logic [7:0]  n_rx_store [olgre_pkg::MAX_BYTES];
    logic [3:0]  r_rx_count, n_rx_count;
    logic [3:0]  r_rx_expected, n_rx_expected;
    logic [15:0] r_elapsed, n_elapsed;
    logic        r_last_error, n_last_error;

    logic        accept;
    logic        have;
    logic        send;
    logic        sync_prefix;
    logic        req_accepted;
    logic [3:0]  sat_len;
    logic [63:0] rdata;
    olgre_pkg::t_emit emit;

    assign o_in_ready  = i_job_ready;
    assign o_job_valid = i_in_valid;
    assign accept      = i_in_valid && i_job_ready;

    always_comb begin
        n_phase       = r_phase;
        n_action      = r_action;
        n_func        = r_func;
        n_addr        = r_addr;
        n_len         = r_len;
        n_is_write    = r_is_write;
        n_data        = r_data;
        n_rx_store    = r_rx_store;
        n_rx_count    = r_rx_count;
        n_rx_expected = r_rx_expected;
        n_elapsed     = r_elapsed;
        n_last_error  = r_last_error;
        have          = 1'b0;
        send          = 1'b0;
        sync_prefix   = 1'b0;
        req_accepted  = 1'b0;
        rdata         = 64'd0;
        emit          = olgre_pkg::EMIT_NONE;
        sat_len = (i_in.dp_length > olgre_pkg::MAX_LEN) ? olgre_pkg::MAX_LEN : i_in.dp_length;

        case (i_in.cmd)
            olgre_pkg::CMD_TICK: begin
                if (n_elapsed != 16'hFFFF) begin
                    n_elapsed = n_elapsed + 16'd1;
                end
            end
            olgre_pkg::CMD_RX: begin
                have = 1'b1;
            end
            olgre_pkg::CMD_REQ: begin
                if (n_action == olgre_pkg::ACT_WAIT) begin
                    n_func     = i_in.func_code;
                    n_addr     = i_in.dp_address;
                    n_len      = sat_len;
                    n_is_write = i_in.is_write;
                    n_data     = i_in.write_data;
                    n_rx_count = 4'd0;
                    for (int k = 0; k < olgre_pkg::MAX_BYTES; k++) begin
                        n_rx_store[k] = 8'h00;
                    end
                    n_action     = olgre_pkg::ACT_PROCESS;
                    req_accepted = 1'b1;
                end
            end
            olgre_pkg::CMD_TAKE_RES: begin
                if (n_action == olgre_pkg::ACT_RETURN) begin
                    for (int k = 0; k < olgre_pkg::MAX_BYTES; k++) begin
                        if (4'(k) < r_len) begin
                            rdata[8*k +: 8] = r_is_write ? r_data[8*k +: 8] : r_rx_store[k];
                        end
                    end
                    n_action = olgre_pkg::ACT_WAIT;
                end
            end
            olgre_pkg::CMD_TAKE_ERR: begin
                n_action = olgre_pkg::ACT_WAIT;
            end
            default: begin
            end
        endcase

        case (n_phase)
            olgre_pkg::PH_INIT: begin
                if (have) begin
                    if (i_in.rx_byte == olgre_pkg::BYTE_SYNC) begin
                        n_elapsed = 16'd0;
                        n_phase   = (n_action == olgre_pkg::ACT_PROCESS) ?
                                    olgre_pkg::PH_SYNC : olgre_pkg::PH_IDLE;
                    end
                end else if (n_elapsed > i_cfg.reset_period_ms) begin
                    n_elapsed = 16'd0;
                    emit      = olgre_pkg::EMIT_RESET;
                end
            end
            olgre_pkg::PH_IDLE: begin
                if (have) begin
                    if (i_in.rx_byte == olgre_pkg::BYTE_SYNC) begin
                        n_elapsed = 16'd0;
                        if (n_action == olgre_pkg::ACT_PROCESS) begin
                            n_phase = olgre_pkg::PH_SYNC;
                        end
                    end
                end else if (n_action == olgre_pkg::ACT_PROCESS &&
                             n_elapsed < {8'd0, i_cfg.quick_window_ms}) begin
                    send = 1'b1;
                end else if (n_elapsed > i_cfg.request_timeout_ms) begin
                    n_phase      = olgre_pkg::PH_INIT;
                    n_last_error = 1'b1;
                end
            end
            olgre_pkg::PH_SYNC: begin
                sync_prefix = 1'b1;
                send        = 1'b1;
            end
            olgre_pkg::PH_SEND: begin
                send = 1'b1;
            end
            olgre_pkg::PH_RECV: begin
                if (have) begin
                    if (n_rx_count < olgre_pkg::MAX_LEN) begin
                        n_rx_store[n_rx_count[2:0]] = i_in.rx_byte;
                    end
                    if (n_rx_count != 4'd15) begin
                        n_rx_count = n_rx_count + 4'd1;
                    end
                end
                if (n_rx_count == n_rx_expected) begin
                    n_phase      = olgre_pkg::PH_IDLE;
                    n_action     = olgre_pkg::ACT_RETURN;
                    n_elapsed    = 16'd0;
                    n_last_error = 1'b0;
                end else if (n_elapsed > i_cfg.answer_timeout_ms) begin
                    n_rx_count   = 4'd0;
                    n_last_error = 1'b1;
                    for (int k = 0; k < olgre_pkg::MAX_BYTES; k++) begin
                        n_rx_store[k] = 8'h00;
                    end
                    n_phase  = olgre_pkg::PH_INIT;
                    n_action = olgre_pkg::ACT_ERROR;
                end
            end
            default: begin
            end
        endcase

        if (send) begin
            emit          = olgre_pkg::EMIT_FRAME;
            n_rx_expected = n_is_write ? 4'd1 : n_len;
            n_rx_count    = 4'd0;
            n_phase       = olgre_pkg::PH_RECV;
        end

        if (n_action == olgre_pkg::ACT_PROCESS && n_elapsed > i_cfg.request_timeout_ms) begin
            n_last_error = 1'b1;
            n_action     = olgre_pkg::ACT_ERROR;
            n_phase      = olgre_pkg::PH_INIT;
        end
    end

    always_comb begin
        o_job.emit        = emit;
        o_job.sync_prefix = sync_prefix;
        o_job.func        = n_func;
        o_job.addr        = n_addr;
        o_job.len         = n_len;
        o_job.is_write    = n_is_write;
        o_job.data        = n_data;
        o_job.accepted    = req_accepted;
        o_job.busy_res    = (n_action != olgre_pkg::ACT_WAIT);
        o_job.outcome     = (n_action == olgre_pkg::ACT_RETURN) ? olgre_pkg::OUTCOME_RESULT :
                            (n_action == olgre_pkg::ACT_ERROR)  ? olgre_pkg::OUTCOME_ERROR :
                                                                  olgre_pkg::OUTCOME_NONE;
        o_job.error_code  = n_last_error;
        o_job.result_data = rdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= olgre_pkg::PH_INIT;
            r_action      <= olgre_pkg::ACT_WAIT;
            r_func        <= 8'd0;
            r_addr        <= 8'd0;
            r_len         <= 4'd0;
            r_is_write    <= 1'b0;
            r_data        <= 64'd0;
            r_rx_count    <= 4'd0;
            r_rx_expected <= 4'd0;
            r_elapsed     <= 16'd0;
            r_last_error  <= 1'b0;
            for (int k = 0; k < olgre_pkg::MAX_BYTES; k++) begin
                r_rx_store[k] <= 8'h00;
            end
        end else if (accept) begin
            r_phase       <= n_phase;
            r_action      <= n_action;
            r_func        <= n_func;
            r_addr        <= n_addr;
            r_len         <= n_len;
            r_is_write    <= n_is_write;
            r_data        <= n_data;
            r_rx_count    <= n_rx_count;
            r_rx_expected <= n_rx_expected;
            r_elapsed     <= n_elapsed;
            r_last_error  <= n_last_error;
            r_rx_store    <= n_rx_store;
        end
    end

endmodule

[hdl/olgre_queue.sv]
module olgre_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_ready,
    input  olgre_pkg::t_job  i_job,
    output logic             o_valid,
    output olgre_pkg::t_job  o_job,
    input  logic             i_pop
);

    olgre_pkg::t_job r_mem [olgre_pkg::QUEUE_DEPTH];
    logic [olgre_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [olgre_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [olgre_pkg::QUEUE_AW:0]   r_count;
    logic do_push;
    logic do_pop;

    assign o_ready = (r_count != (olgre_pkg::QUEUE_AW + 1)'(olgre_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[hdl/olgre_back.sv]
module olgre_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    input  olgre_pkg::t_job  i_job,
    output logic             o_job_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output olgre_pkg::t_out  o_out
);

    logic [3:0] r_idx;
    logic       r_out_valid;
    olgre_pkg::t_out r_out;

    logic [3:0] total;
    logic [3:0] pos;
    logic [3:0] dpos;
    logic [7:0] data_byte;
    logic [7:0] tx_byte;
    logic       is_last;
    logic       load;

    always_comb begin
        if (i_job.emit == olgre_pkg::EMIT_FRAME) begin
            total = 4'd4 + {3'd0, i_job.sync_prefix} + (i_job.is_write ? i_job.len : 4'd0);
        end else begin
            total = 4'd1;
        end
        pos  = r_idx - {3'd0, i_job.sync_prefix};
        dpos = pos - 4'd3;
        data_byte = 8'h00;
        for (int k = 0; k < olgre_pkg::MAX_BYTES; k++) begin
            if (dpos[2:0] == 3'(k)) begin
                data_byte = i_job.data[8*k +: 8];
            end
        end
        case (i_job.emit)
            olgre_pkg::EMIT_RESET: tx_byte = olgre_pkg::BYTE_RESET;
            olgre_pkg::EMIT_FRAME: begin
                if (i_job.sync_prefix && r_idx == 4'd0) begin
                    tx_byte = olgre_pkg::BYTE_START;
                end else if (pos == 4'd0) begin
                    tx_byte = i_job.func;
                end else if (pos == 4'd1) begin
                    tx_byte = i_job.addr;
                end else if (pos == 4'd2) begin
                    tx_byte = {4'd0, i_job.len};
                end else if (i_job.is_write && dpos < i_job.len) begin
                    tx_byte = data_byte;
                end else begin
                    tx_byte = olgre_pkg::BYTE_RESET;
                end
            end
            default: tx_byte = 8'h00;
        endcase
        is_last = (r_idx == total - 4'd1);
    end

    assign load        = i_job_valid && (!r_out_valid || i_out_ready);
    assign o_job_pop   = load && is_last;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.tx_valid    <= (i_job.emit != olgre_pkg::EMIT_NONE);
            r_out.tx_byte     <= tx_byte;
            r_out.last        <= is_last;
            r_out.accepted    <= i_job.accepted;
            r_out.busy_res    <= i_job.busy_res;
            r_out.outcome     <= i_job.outcome;
            r_out.error_code  <= i_job.error_code;
            r_out.result_data <= i_job.result_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_idx       <= is_last ? 4'd0 : r_idx + 4'd1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

[hdl/optical_link_gwg_request_engine_unit.sv]
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_ready   i_in  (olgre_pkg::t_in)
// result    out        o_out_valid / i_out_ready o_out (olgre_pkg::t_out)
// config    in         i_cfg_we (write only)     i_cfg_index, i_cfg_data
//
// The front takes one transaction per cycle unless the queue is full, and updates the protocol state
// in that cycle. The back sends one result per cycle unless i_out_ready holds it back; an item stays
// at the head of the queue until its byte sequencer has walked through every byte of its frame.
// A two-entry queue sits between them; the front stalls only when it is full.
// Reset is synchronous and returns the control and config registers to their defaults and the link to init.
module optical_link_gwg_request_engine_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  olgre_pkg::t_in  i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output olgre_pkg::t_out o_out,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_index,
    input  logic [15:0]     i_cfg_data
);

    olgre_pkg::t_cfg r_cfg;
    olgre_pkg::t_job front_job;
    olgre_pkg::t_job queue_job;
    logic front_valid;
    logic queue_ready;
    logic queue_valid;
    logic queue_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_period_ms    <= 16'd1000;
            r_cfg.request_timeout_ms <= 16'd5000;
            r_cfg.answer_timeout_ms  <= 16'd1000;
            r_cfg.quick_window_ms    <= 8'd10;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                olgre_pkg::CFG_RESET_PERIOD:    r_cfg.reset_period_ms    <= i_cfg_data;
                olgre_pkg::CFG_REQUEST_TIMEOUT: r_cfg.request_timeout_ms <= i_cfg_data;
                olgre_pkg::CFG_ANSWER_TIMEOUT:  r_cfg.answer_timeout_ms  <= i_cfg_data;
                olgre_pkg::CFG_QUICK_WINDOW:    r_cfg.quick_window_ms    <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    olgre_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_cfg       (r_cfg),
        .o_job_valid (front_valid),
        .o_job       (front_job),
        .i_job_ready (queue_ready)
    );

    olgre_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .o_ready (queue_ready),
        .i_job   (front_job),
        .o_valid (queue_valid),
        .o_job   (queue_job),
        .i_pop   (queue_pop)
    );

    olgre_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (queue_valid),
        .i_job       (queue_job),
        .o_job_pop   (queue_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    a_silent_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.tx_valid |-> o_out.last)
        else $error("result without a byte is not marked last");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.accepted |-> o_out.busy_res)
        else $error("accepted request does not show busy");

    a_error_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.outcome == olgre_pkg::OUTCOME_ERROR |-> o_out.error_code)
        else $error("error outcome without error code");

endmodule

[bench/optical_link_gwg_request_engine_unit_checker.sv]
`timescale 1ns / 1ps

module optical_link_gwg_request_engine_unit_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_ready,
    input  olgre_pkg::t_in  i_in,
    input  logic            i_out_valid,
    input  logic            i_out_ready,
    input  olgre_pkg::t_out i_out,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_index,
    input  logic [15:0]     i_cfg_data,
    output int              o_fail_count,
    output int              o_pending
);

    olgre_pkg::t_cfg    settings;
    olgre_pkg::t_phase  link_phase;
    olgre_pkg::t_action req_action;
    logic [7:0]  req_func;
    logic [7:0]  req_addr;
    logic [3:0]  req_len;
    logic        req_write;
    logic [63:0] req_data;
    logic [7:0]  answer_bytes [8];
    logic [3:0]  answer_count;
    logic [3:0]  answer_needed;
    logic [15:0] ms_since_mark;
    logic        link_error;

    logic [7:0]      frame_bytes [$];
    olgre_pkg::t_out pending_results [$];
    olgre_pkg::t_out oldest;
    int              fail_count = 0;

    function automatic void emit_byte(logic [7:0] b);
        if (frame_bytes.size() < 16) begin
            frame_bytes.push_back(b);
        end
    endfunction

    function automatic void send_request_frame();
        emit_byte(req_func);
        emit_byte(req_addr);
        emit_byte({4'd0, req_len});
        if (req_write) begin
            for (int k = 0; k < olgre_pkg::MAX_BYTES; k++) begin
                if (k < req_len) begin
                    emit_byte(req_data[8*k +: 8]);
                end
            end
            emit_byte(olgre_pkg::BYTE_RESET);
            answer_needed = 4'd1;
        end else begin
            emit_byte(olgre_pkg::BYTE_RESET);
            answer_needed = req_len;
        end
        answer_count = 4'd0;
        link_phase = olgre_pkg::PH_RECV;
    endfunction

    function automatic void idle_link_step(logic have, logic [7:0] b);
        if (have) begin
            if (b == olgre_pkg::BYTE_SYNC) begin
                ms_since_mark = 16'd0;
                if (req_action == olgre_pkg::ACT_PROCESS) begin
                    link_phase = olgre_pkg::PH_SYNC;
                end
            end
        end else if (req_action == olgre_pkg::ACT_PROCESS &&
                     ms_since_mark < {8'd0, settings.quick_window_ms}) begin
            send_request_frame();
        end else if (ms_since_mark > settings.request_timeout_ms) begin
            link_phase = olgre_pkg::PH_INIT;
            link_error = 1'b1;
        end
    endfunction

    function automatic void link_engine_step(logic have, logic [7:0] b);
        case (link_phase)
            olgre_pkg::PH_INIT: begin
                if (have) begin
                    if (b == olgre_pkg::BYTE_SYNC) begin
                        link_phase = olgre_pkg::PH_IDLE;
                        idle_link_step(1'b1, b);
                    end
                end else if (ms_since_mark > settings.reset_period_ms) begin
                    ms_since_mark = 16'd0;
                    emit_byte(olgre_pkg::BYTE_RESET);
                end
            end
            olgre_pkg::PH_IDLE: begin
                idle_link_step(have, b);
            end
            olgre_pkg::PH_SYNC: begin
                emit_byte(olgre_pkg::BYTE_START);
                send_request_frame();
            end
            olgre_pkg::PH_SEND: begin
                send_request_frame();
            end
            default: begin
                if (have) begin
                    if (answer_count < olgre_pkg::MAX_LEN) begin
                        answer_bytes[answer_count[2:0]] = b;
                    end
                    if (answer_count < 4'd15) begin
                        answer_count++;
                    end
                end
                if (answer_count == answer_needed) begin
                    link_phase = olgre_pkg::PH_IDLE;
                    req_action = olgre_pkg::ACT_RETURN;
                    ms_since_mark = 16'd0;
                    link_error = 1'b0;
                end else if (ms_since_mark > settings.answer_timeout_ms) begin
                    answer_count = 4'd0;
                    link_error = 1'b1;
                    answer_bytes = '{default: '0};
                    link_phase = olgre_pkg::PH_INIT;
                    req_action = olgre_pkg::ACT_ERROR;
                end
            end
        endcase
        if (req_action == olgre_pkg::ACT_PROCESS &&
            ms_since_mark > settings.request_timeout_ms) begin
            link_error = 1'b1;
            req_action = olgre_pkg::ACT_ERROR;
            link_phase = olgre_pkg::PH_INIT;
        end
    endfunction

    function automatic void forecast_results(olgre_pkg::t_in item);
        logic            took;
        logic [63:0]     delivered;
        olgre_pkg::t_out res;
        int              n;
        took = 1'b0;
        delivered = '0;
        frame_bytes.delete();
        case (item.cmd)
            olgre_pkg::CMD_TICK: begin
                if (ms_since_mark != 16'hFFFF) begin
                    ms_since_mark++;
                end
                link_engine_step(1'b0, 8'd0);
            end
            olgre_pkg::CMD_RX: begin
                link_engine_step(1'b1, item.rx_byte);
            end
            default: begin
                if (item.cmd == olgre_pkg::CMD_REQ) begin
                    if (req_action == olgre_pkg::ACT_WAIT) begin
                        req_func = item.func_code;
                        req_addr = item.dp_address;
                        req_len = (item.dp_length > olgre_pkg::MAX_LEN) ? olgre_pkg::MAX_LEN
                                                                        : item.dp_length;
                        req_write = item.is_write;
                        req_data = item.write_data;
                        answer_count = 4'd0;
                        answer_bytes = '{default: '0};
                        req_action = olgre_pkg::ACT_PROCESS;
                        took = 1'b1;
                    end
                end else if (item.cmd == olgre_pkg::CMD_TAKE_RES) begin
                    if (req_action == olgre_pkg::ACT_RETURN) begin
                        for (int k = 0; k < olgre_pkg::MAX_BYTES; k++) begin
                            if (k < req_len) begin
                                delivered[8*k +: 8] = req_write ? req_data[8*k +: 8]
                                                                : answer_bytes[k];
                            end
                        end
                        req_action = olgre_pkg::ACT_WAIT;
                    end
                end else if (item.cmd == olgre_pkg::CMD_TAKE_ERR) begin
                    req_action = olgre_pkg::ACT_WAIT;
                end
                link_engine_step(1'b0, 8'd0);
            end
        endcase

        res.accepted = took;
        res.busy_res = (req_action != olgre_pkg::ACT_WAIT);
        res.outcome = (req_action == olgre_pkg::ACT_RETURN) ? olgre_pkg::OUTCOME_RESULT :
                      (req_action == olgre_pkg::ACT_ERROR) ? olgre_pkg::OUTCOME_ERROR :
                                                             olgre_pkg::OUTCOME_NONE;
        res.error_code = link_error;
        res.result_data = delivered;
        n = (frame_bytes.size() > 0) ? frame_bytes.size() : 1;
        for (int i = 0; i < n; i++) begin
            res.tx_valid = (frame_bytes.size() > 0);
            res.tx_byte = (frame_bytes.size() > 0) ? frame_bytes[i] : 8'd0;
            res.last = (i == n - 1);
            pending_results.push_back(res);
        end
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            settings.reset_period_ms = 16'd1000;
            settings.request_timeout_ms = 16'd5000;
            settings.answer_timeout_ms = 16'd1000;
            settings.quick_window_ms = 8'd10;
            link_phase = olgre_pkg::PH_INIT;
            req_action = olgre_pkg::ACT_WAIT;
            req_func = '0;
            req_addr = '0;
            req_len = '0;
            req_write = 1'b0;
            req_data = '0;
            answer_bytes = '{default: '0};
            answer_count = '0;
            answer_needed = '0;
            ms_since_mark = '0;
            link_error = 1'b0;
            pending_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    olgre_pkg::CFG_RESET_PERIOD:    settings.reset_period_ms = i_cfg_data;
                    olgre_pkg::CFG_REQUEST_TIMEOUT: settings.request_timeout_ms = i_cfg_data;
                    olgre_pkg::CFG_ANSWER_TIMEOUT:  settings.answer_timeout_ms = i_cfg_data;
                    olgre_pkg::CFG_QUICK_WINDOW:    settings.quick_window_ms = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                forecast_results(i_in);
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result with no expectation: tx_valid %0b tx_byte %0h",
                           i_out.tx_valid, i_out.tx_byte);
                    fail_count++;
                end else begin
                    oldest = pending_results.pop_front();
                    check_field("tx_valid", 64'(oldest.tx_valid), 64'(i_out.tx_valid));
                    check_field("tx_byte", 64'(oldest.tx_byte), 64'(i_out.tx_byte));
                    check_field("last", 64'(oldest.last), 64'(i_out.last));
                    check_field("accepted", 64'(oldest.accepted), 64'(i_out.accepted));
                    check_field("busy_res", 64'(oldest.busy_res), 64'(i_out.busy_res));
                    check_field("outcome", 64'(oldest.outcome), 64'(i_out.outcome));
                    check_field("error_code", 64'(oldest.error_code), 64'(i_out.error_code));
                    check_field("result_data", oldest.result_data, i_out.result_data);
                end
            end
        end
        o_pending = pending_results.size();
        o_fail_count = fail_count;
    end

endmodule

[bench/optical_link_gwg_request_engine_unit_test.sv]
`timescale 1ns / 1ps

module optical_link_gwg_request_engine_unit_test;

    localparam int PHASE_ITEMS = 45;
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam logic [7:0] ANSWER_PATTERN [8] = '{
        8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h01, 8'h80, 8'h7F, 8'h3C
    };

    logic            clk;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_ready;
    olgre_pkg::t_in  in_data = '0;
    logic            out_valid;
    logic            out_ready = 1'b0;
    olgre_pkg::t_out out_data;
    logic            cfg_we = 1'b0;
    logic [1:0]      cfg_index = '0;
    logic [15:0]     cfg_data = '0;
    int              fail_count;
    int              pending;

    int send_gap_pct = 0;
    int recv_gap_pct = 0;
    int item_count = 0;
    int stall_requests = 0;
    int stalls_served = 0;
    int quiet_cycles = 0;

    optical_link_gwg_request_engine_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    optical_link_gwg_request_engine_unit_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        forever begin
            @(posedge clk);
            if (stall_requests != stalls_served) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                stalls_served = stall_requests;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_gap_pct);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("optical_link_gwg_request_engine_unit_test NOT OK");
            $finish;
        end
    end

    function automatic olgre_pkg::t_in random_item(logic [2:0] cmd);
        olgre_pkg::t_in it;
        it.cmd = cmd;
        it.rx_byte = 8'($urandom);
        it.func_code = 8'($urandom);
        it.dp_address = 8'($urandom);
        it.dp_length = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                                 : 4'($urandom_range(8));
        it.is_write = 1'($urandom);
        it.write_data = {$urandom, $urandom};
        return it;
    endfunction

    function automatic olgre_pkg::t_in byte_item(logic [7:0] b);
        olgre_pkg::t_in it;
        it = random_item(olgre_pkg::CMD_RX);
        it.rx_byte = b;
        return it;
    endfunction

    task automatic send_item(input olgre_pkg::t_in item);
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        item_count++;
    endtask

    task automatic load_settings(input logic [15:0] period, input logic [15:0] req_limit,
                                 input logic [15:0] answer_limit, input logic [7:0] window);
        cfg_we <= 1'b1;
        cfg_index <= olgre_pkg::CFG_RESET_PERIOD;
        cfg_data <= period;
        @(posedge clk);
        cfg_index <= olgre_pkg::CFG_REQUEST_TIMEOUT;
        cfg_data <= req_limit;
        @(posedge clk);
        cfg_index <= olgre_pkg::CFG_ANSWER_TIMEOUT;
        cfg_data <= answer_limit;
        @(posedge clk);
        cfg_index <= olgre_pkg::CFG_QUICK_WINDOW;
        cfg_data <= {8'd0, window};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic run_exchange();
        olgre_pkg::t_in req;
        int  answer_len;
        int  roll;
        req = random_item(olgre_pkg::CMD_REQ);
        if ($urandom_range(1) == 0) begin
            send_item(byte_item(olgre_pkg::BYTE_SYNC));
        end
        send_item(req);
        if ($urandom_range(9) < 7) begin
            send_item(byte_item(olgre_pkg::BYTE_SYNC));
            send_item(random_item(olgre_pkg::CMD_TICK));
        end
        if (req.is_write) begin
            answer_len = 1;
        end else begin
            answer_len = (req.dp_length > olgre_pkg::MAX_LEN) ? olgre_pkg::MAX_BYTES
                                                              : int'(req.dp_length);
        end
        roll = $urandom_range(9);
        if (roll == 0) begin
            answer_len += $urandom_range(1, 9);
        end else if (roll == 1) begin
            answer_len = 0;
        end
        if ($urandom_range(2) == 0) begin
            repeat ($urandom_range(1, 3)) send_item(random_item(olgre_pkg::CMD_TICK));
        end
        repeat (answer_len) send_item(random_item(olgre_pkg::CMD_RX));
        if (roll == 1) begin
            repeat ($urandom_range(2, 12)) send_item(random_item(olgre_pkg::CMD_TICK));
        end
        roll = $urandom_range(19);
        if (roll < 16) begin
            send_item(random_item(olgre_pkg::CMD_TAKE_RES));
        end else if (roll < 19) begin
            send_item(random_item(olgre_pkg::CMD_TAKE_ERR));
        end
    endtask

    task automatic random_phase();
        int start;
        start = item_count;
        while (item_count - start < PHASE_ITEMS) begin
            if ($urandom_range(3) != 0) begin
                run_exchange();
            end else begin
                repeat ($urandom_range(1, 3)) send_item(random_item(3'($urandom_range(7))));
            end
        end
    endtask

    initial begin
        olgre_pkg::t_in it;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_settings(16'd1, 16'd20, 16'd4, 8'd0);
        send_gap_pct = 9;
        recv_gap_pct = 68;
        send_item(random_item(olgre_pkg::CMD_TICK));
        send_item(random_item(olgre_pkg::CMD_TICK));
        send_item(byte_item(8'h33));
        for (int c = olgre_pkg::CMD_TAKE_ERR + 1; c < 8; c++) begin
            it = '1;
            it.cmd = 3'(c);
            send_item(it);
        end
        send_item(random_item(olgre_pkg::CMD_TAKE_RES));
        it = '1;
        it.cmd = olgre_pkg::CMD_REQ;
        it.dp_address = 8'h00;
        it.is_write = 1'b0;
        send_item(it);
        it = '0;
        it.cmd = olgre_pkg::CMD_REQ;
        it.dp_address = 8'hFF;
        it.is_write = 1'b1;
        send_item(it);
        send_item(byte_item(olgre_pkg::BYTE_SYNC));
        send_item(byte_item(8'hAA));
        for (int k = 0; k < 8; k++) begin
            send_item(byte_item(ANSWER_PATTERN[k]));
        end
        send_item(random_item(olgre_pkg::CMD_TAKE_RES));
        it = '0;
        it.cmd = olgre_pkg::CMD_REQ;
        it.func_code = 8'hA5;
        it.dp_address = 8'h3C;
        it.dp_length = olgre_pkg::MAX_LEN;
        it.is_write = 1'b1;
        it.write_data = 64'h0123_4567_89AB_CDEF;
        send_item(it);
        send_item(byte_item(olgre_pkg::BYTE_SYNC));
        repeat (6) send_item(random_item(olgre_pkg::CMD_TICK));
        send_item(random_item(olgre_pkg::CMD_TAKE_ERR));
        drain_results();

        load_settings(16'd3, 16'd30, 16'd8, 8'd4);
        random_phase();
        drain_results();

        send_gap_pct = 68;
        recv_gap_pct = 9;
        load_settings(16'd5, 16'd1, 16'd1, 8'hFF);
        random_phase();
        drain_results();

        send_gap_pct = 0;
        recv_gap_pct = 0;
        load_settings(16'd2, 16'd400, 16'd20, 8'd6);
        stall_requests++;
        random_phase();
        drain_results();

        if (fail_count == 0) begin
            $display("optical_link_gwg_request_engine_unit_test OK");
        end else begin
            $display("optical_link_gwg_request_engine_unit_test NOT OK");
        end
        $finish;
    end

endmodule
